@@ src/sste_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sste_pkg
// Shared codes and types of the small set table engine: opcodes, status
// codes, result limits and the sequencer state type.
// ----------------------------------------------------------------------------
package sste_pkg;

   // operation selector carried in the request word
   localparam logic [2:0] OP_CREATE    = 3'd0;
   localparam logic [2:0] OP_INSERT    = 3'd1;
   localparam logic [2:0] OP_REMOVE    = 3'd2;
   localparam logic [2:0] OP_UNION     = 3'd3;
   localparam logic [2:0] OP_INTERSECT = 3'd4;
   localparam logic [2:0] OP_SEARCH    = 3'd5;
   localparam logic [2:0] OP_READ      = 3'd6;
   // unused code: no change and no response word
   localparam logic [2:0] OP_SPARE     = 3'd7;

   // status carried in the response word
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_NO_ROOM   = 3'd1;
   localparam logic [2:0] ST_BAD_SET   = 3'd2;
   localparam logic [2:0] ST_PRESENT   = 3'd3;
   localparam logic [2:0] ST_TOO_LARGE = 3'd4;
   localparam logic [2:0] ST_NONE      = 3'd5;

   // most response words one search or read returns
   localparam int RESULT_CAP = 16;
   localparam int KW         = $clog2(RESULT_CAP + 1);

   typedef enum logic [4:0] {
      S_IDLE,
      S_DECODE,
      S_CLR,
      S_REM_RD,
      S_REM_WR,
      S_INS_RD,
      S_INS_EX,
      S_INS_END,
      S_LEN_RD,
      S_LEN_EX,
      S_OUT_RD,
      S_OUT_EX,
      S_INN_RD,
      S_INN_EX,
      S_PUT,
      S_NEXT,
      S_SCAN_RD,
      S_SCAN_EX,
      S_HIT,
      S_FINAL,
      S_RESP
   } state_type;

endpackage
`default_nettype wire

@@ src/small_set_table_engine.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// small_set_table_engine
// Table of small sets of nonzero signed values held in one slot memory,
// with create, insert, remove, union, intersect, search and read-out.
// ----------------------------------------------------------------------------
//  channel | dir | tuser       | tdata                                | tlast
//  req_    | in  | opcode      | first_set, second_set, value         | -
//  rsp_    | out | status      | set_index, element                   | last word
//
//  Every slot visit is a memory read plus an evaluate step (registered
//  read, one read and one write port). Create sweeps the new row, insert
//  scans the row and then writes the value, remove moves each later row
//  down by one and then clears the last row, search and read visit the
//  slots in turn, and union and intersect run nested slot compares.
//  One word is taken at a time; the next is taken once the last response
//  word is loaded into the output register. A stalled response holds the
//  sequencer only when it has a further word to give. Reset clears the set
//  count; each row is swept to zero when its set is created.
module small_set_table_engine #(
   parameter int NUM_SETS  = 8,
   parameter int SET_SLOTS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,   // first_set[2:0], second_set[5:3], value[37:6]
   input  wire logic [2:0]  req_tuser,   // opcode[2:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // set_index[2:0], element[34:3]
   output logic [2:0]       rsp_tuser,   // status[2:0]
   output logic             rsp_tlast
);

   localparam int RW    = $clog2(NUM_SETS);
   localparam int SW    = $clog2(SET_SLOTS);
   localparam int CW    = $clog2(NUM_SETS + 1);
   localparam int SCW   = $clog2(SET_SLOTS + 1);
   localparam int LW    = SCW + 1;
   localparam int DEPTH = NUM_SETS * SET_SLOTS;
   localparam int AW    = $clog2(DEPTH);
   localparam int XW    = (CW > 3) ? CW : 3;

   sste_pkg::state_type state_ff, state_in;

   logic [2:0]          op_ff, op_in;
   logic [2:0]          a_ff, a_in;
   logic [2:0]          b_ff, b_in;
   logic [31:0]         v_ff, v_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       row_ff, row_in;
   logic [SCW-1:0]      i_ff, i_in;
   logic [SCW-1:0]      j_ff, j_in;
   logic [SCW-1:0]      pos_ff, pos_in;
   logic [LW-1:0]       cnt_ff, cnt_in;
   logic                pass_ff, pass_in;
   logic                inner_b_ff, inner_b_in;
   logic                end_ff, end_in;
   logic [31:0]         x_ff, x_in;
   logic [sste_pkg::KW-1:0] k_ff, k_in;
   logic                pend_valid_ff, pend_valid_in;
   logic [2:0]          pend_idx_ff, pend_idx_in;
   logic [31:0]         pend_elem_ff, pend_elem_in;
   logic [2:0]          hit_idx_ff, hit_idx_in;
   logic [31:0]         hit_elem_ff, hit_elem_in;
   logic [2:0]          res_status_ff, res_status_in;
   logic [2:0]          res_idx_ff, res_idx_in;

   logic                rsp_valid_ff;
   logic [2:0]          rsp_status_ff;
   logic [2:0]          rsp_idx_ff;
   logic [31:0]         rsp_elem_ff;
   logic                rsp_last_ff;

   // slot memory and its ports
   logic [31:0]         slot_mem [DEPTH];
   logic [31:0]         rd_data_ff;
   logic                mem_we;
   logic [RW-1:0]       mem_wrow, mem_rrow;
   logic [SW-1:0]       mem_wslot, mem_rslot;
   logic [31:0]         mem_wdata;
   logic [AW-1:0]       mem_waddr, mem_raddr;

   // output load
   logic                out_free, out_load, out_last;
   logic [2:0]          out_status, out_idx;
   logic [31:0]         out_elem;

   // shared compares
   logic                a_bad, b_bad, count_full, i_last, j_last, pos_full, rd_nz;
   logic                row_next_end;
   logic [LW-1:0]       cnt_nx;

   assign a_bad        = XW'(a_ff) >= XW'(count_ff);
   assign b_bad        = XW'(b_ff) >= XW'(count_ff);
   assign count_full   = count_ff == CW'(NUM_SETS);
   assign i_last       = i_ff == SCW'(SET_SLOTS - 1);
   assign j_last       = j_ff == SCW'(SET_SLOTS - 1);
   assign pos_full     = pos_ff == SCW'(SET_SLOTS);
   assign rd_nz        = rd_data_ff != '0;
   assign row_next_end = ({1'b0, row_ff} + (CW+1)'(1)) == {1'b0, count_ff};
   assign cnt_nx       = cnt_ff + LW'(rd_nz);

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign mem_waddr = AW'(mem_wrow) * AW'(SET_SLOTS) + AW'(mem_wslot);
   assign mem_raddr = AW'(mem_rrow) * AW'(SET_SLOTS) + AW'(mem_rslot);

   assign req_tready = state_ff == sste_pkg::S_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {5'd0, rsp_elem_ff, rsp_idx_ff};

   // slot memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= slot_mem[mem_raddr];
   end

   // sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= sste_pkg::S_IDLE;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         pos_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         pos_ff        <= pos_in;
      end
      op_ff         <= op_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      v_ff          <= v_in;
      row_ff        <= row_in;
      i_ff          <= i_in;
      j_ff          <= j_in;
      cnt_ff        <= cnt_in;
      pass_ff       <= pass_in;
      inner_b_ff    <= inner_b_in;
      end_ff        <= end_in;
      x_ff          <= x_in;
      k_ff          <= k_in;
      pend_idx_ff   <= pend_idx_in;
      pend_elem_ff  <= pend_elem_in;
      hit_idx_ff    <= hit_idx_in;
      hit_elem_ff   <= hit_elem_in;
      res_status_ff <= res_status_in;
      res_idx_ff    <= res_idx_in;
   end

   // output register: load a word, drop it once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (out_load) begin
         rsp_status_ff <= out_status;
         rsp_idx_ff    <= out_idx;
         rsp_elem_ff   <= out_elem;
         rsp_last_ff   <= out_last;
      end
   end

   // next state, memory access and output load
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      v_in          = v_ff;
      count_in      = count_ff;
      row_in        = row_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      pos_in        = pos_ff;
      cnt_in        = cnt_ff;
      pass_in       = pass_ff;
      inner_b_in    = inner_b_ff;
      end_in        = end_ff;
      x_in          = x_ff;
      k_in          = k_ff;
      pend_valid_in = pend_valid_ff;
      pend_idx_in   = pend_idx_ff;
      pend_elem_in  = pend_elem_ff;
      hit_idx_in    = hit_idx_ff;
      hit_elem_in   = hit_elem_ff;
      res_status_in = res_status_ff;
      res_idx_in    = res_idx_ff;
      mem_we        = 1'b0;
      mem_wrow      = row_ff[RW-1:0];
      mem_wslot     = i_ff[SW-1:0];
      mem_wdata     = '0;
      mem_rrow      = row_ff[RW-1:0];
      mem_rslot     = i_ff[SW-1:0];
      out_load      = 1'b0;
      out_status    = sste_pkg::ST_OK;
      out_idx       = '0;
      out_elem      = '0;
      out_last      = 1'b1;

      unique case (state_ff)
         sste_pkg::S_IDLE: begin
            if (req_tvalid) begin
               op_in    = req_tuser;
               a_in     = req_tdata[2:0];
               b_in     = req_tdata[5:3];
               v_in     = req_tdata[37:6];
               state_in = sste_pkg::S_DECODE;
            end
         end

         // check operands and start the operation
         sste_pkg::S_DECODE: begin
            res_idx_in = '0;
            i_in       = '0;
            k_in       = '0;
            pend_valid_in = 1'b0;
            unique case (op_ff)
               sste_pkg::OP_CREATE: begin
                  if (count_full) begin
                     res_status_in = sste_pkg::ST_NO_ROOM;
                     state_in      = sste_pkg::S_RESP;
                  end else begin
                     row_in   = count_ff;
                     state_in = sste_pkg::S_CLR;
                  end
               end
               sste_pkg::OP_INSERT: begin
                  pos_in = '0;
                  if (a_bad) begin
                     res_status_in = sste_pkg::ST_BAD_SET;
                     state_in      = sste_pkg::S_RESP;
                  end else if (v_ff == '0) begin
                     res_status_in = sste_pkg::ST_OK;
                     state_in      = sste_pkg::S_RESP;
                  end else begin
                     state_in = sste_pkg::S_INS_RD;
                  end
               end
               sste_pkg::OP_REMOVE: begin
                  if (a_bad) begin
                     res_status_in = sste_pkg::ST_BAD_SET;
                     state_in      = sste_pkg::S_RESP;
                  end else if (XW'(a_ff) + XW'(1) == XW'(count_ff)) begin
                     row_in   = count_ff - CW'(1);
                     state_in = sste_pkg::S_CLR;
                  end else begin
                     row_in   = CW'(a_ff);
                     state_in = sste_pkg::S_REM_RD;
                  end
               end
               sste_pkg::OP_UNION, sste_pkg::OP_INTERSECT: begin
                  cnt_in  = '0;
                  pass_in = 1'b0;
                  if (a_bad || b_bad || a_ff == b_ff) begin
                     res_status_in = sste_pkg::ST_BAD_SET;
                     state_in      = sste_pkg::S_RESP;
                  end else if (count_full) begin
                     res_status_in = sste_pkg::ST_NO_ROOM;
                     state_in      = sste_pkg::S_RESP;
                  end else if (op_ff == sste_pkg::OP_UNION) begin
                     row_in   = CW'(a_ff);
                     state_in = sste_pkg::S_LEN_RD;
                  end else begin
                     row_in   = count_ff;
                     state_in = sste_pkg::S_CLR;
                  end
               end
               sste_pkg::OP_SEARCH: begin
                  row_in = '0;
                  if (v_ff == '0 || count_ff == '0) begin
                     state_in = sste_pkg::S_FINAL;
                  end else begin
                     state_in = sste_pkg::S_SCAN_RD;
                  end
               end
               sste_pkg::OP_READ: begin
                  row_in = CW'(a_ff);
                  if (a_bad) begin
                     res_status_in = sste_pkg::ST_BAD_SET;
                     state_in      = sste_pkg::S_RESP;
                  end else begin
                     state_in = sste_pkg::S_SCAN_RD;
                  end
               end
               default: begin
                  state_in = sste_pkg::S_IDLE;
               end
            endcase
         end

         // sweep one row to zero
         sste_pkg::S_CLR: begin
            mem_we = 1'b1;
            if (i_last) begin
               i_in   = '0;
               pos_in = '0;
               unique case (op_ff)
                  sste_pkg::OP_CREATE: begin
                     res_status_in = sste_pkg::ST_OK;
                     res_idx_in    = 3'(count_ff);
                     count_in      = count_ff + CW'(1);
                     state_in      = sste_pkg::S_RESP;
                  end
                  sste_pkg::OP_REMOVE: begin
                     res_status_in = sste_pkg::ST_OK;
                     count_in      = count_ff - CW'(1);
                     state_in      = sste_pkg::S_RESP;
                  end
                  sste_pkg::OP_UNION, sste_pkg::OP_INTERSECT: begin
                     pass_in  = 1'b0;
                     state_in = sste_pkg::S_OUT_RD;
                  end
                  default: begin
                     state_in = sste_pkg::S_IDLE;
                  end
               endcase
            end else begin
               i_in = i_ff + SCW'(1);
            end
         end

         // shift the later rows down by one
         sste_pkg::S_REM_RD: begin
            mem_rrow = RW'(row_ff + CW'(1));
            state_in = sste_pkg::S_REM_WR;
         end
         sste_pkg::S_REM_WR: begin
            mem_we    = 1'b1;
            mem_wdata = rd_data_ff;
            row_in    = row_ff;
            if (i_last) begin
               i_in   = '0;
               row_in = row_ff + CW'(1);
               if (({1'b0, row_ff} + (CW+1)'(2)) == {1'b0, count_ff}) begin
                  state_in = sste_pkg::S_CLR;
               end else begin
                  state_in = sste_pkg::S_REM_RD;
               end
            end else begin
               i_in     = i_ff + SCW'(1);
               state_in = sste_pkg::S_REM_RD;
            end
         end

         // insert: look for the value and count the filled slots
         sste_pkg::S_INS_RD: begin
            mem_rrow = RW'(a_ff);
            state_in = sste_pkg::S_INS_EX;
         end
         sste_pkg::S_INS_EX: begin
            if (rd_data_ff == v_ff) begin
               res_status_in = sste_pkg::ST_PRESENT;
               state_in      = sste_pkg::S_RESP;
            end else begin
               pos_in = pos_ff + SCW'(rd_nz);
               if (i_last) begin
                  state_in = sste_pkg::S_INS_END;
               end else begin
                  i_in     = i_ff + SCW'(1);
                  state_in = sste_pkg::S_INS_RD;
               end
            end
         end
         sste_pkg::S_INS_END: begin
            state_in = sste_pkg::S_RESP;
            if (pos_full) begin
               res_status_in = sste_pkg::ST_NO_ROOM;
            end else begin
               mem_we        = 1'b1;
               mem_wrow      = RW'(a_ff);
               mem_wslot     = pos_ff[SW-1:0];
               mem_wdata     = v_ff;
               res_status_in = sste_pkg::ST_OK;
            end
         end

         // union: sum the sizes of both operands
         sste_pkg::S_LEN_RD: begin
            state_in = sste_pkg::S_LEN_EX;
         end
         sste_pkg::S_LEN_EX: begin
            cnt_in = cnt_nx;
            if (i_last) begin
               i_in = '0;
               if (!pass_ff) begin
                  pass_in  = 1'b1;
                  row_in   = CW'(b_ff);
                  state_in = sste_pkg::S_LEN_RD;
               end else if (cnt_nx > LW'(SET_SLOTS)) begin
                  res_status_in = sste_pkg::ST_TOO_LARGE;
                  state_in      = sste_pkg::S_RESP;
               end else begin
                  row_in   = count_ff;
                  state_in = sste_pkg::S_CLR;
               end
            end else begin
               i_in     = i_ff + SCW'(1);
               state_in = sste_pkg::S_LEN_RD;
            end
         end

         // merge: fetch the next source element
         sste_pkg::S_OUT_RD: begin
            mem_rrow = pass_ff ? RW'(b_ff) : RW'(a_ff);
            state_in = sste_pkg::S_OUT_EX;
         end
         sste_pkg::S_OUT_EX: begin
            x_in = rd_data_ff;
            j_in = '0;
            if (!rd_nz) begin
               state_in = sste_pkg::S_NEXT;
            end else if (op_ff == sste_pkg::OP_UNION) begin
               inner_b_in = 1'b0;
               state_in   = (pos_ff == '0) ? sste_pkg::S_PUT : sste_pkg::S_INN_RD;
            end else begin
               inner_b_in = 1'b1;
               state_in   = sste_pkg::S_INN_RD;
            end
         end

         // inner compare against the second operand or the new set
         sste_pkg::S_INN_RD: begin
            mem_rrow  = inner_b_ff ? RW'(b_ff) : count_ff[RW-1:0];
            mem_rslot = j_ff[SW-1:0];
            state_in  = sste_pkg::S_INN_EX;
         end
         sste_pkg::S_INN_EX: begin
            if (inner_b_ff) begin
               if (rd_data_ff == x_ff) begin
                  inner_b_in = 1'b0;
                  j_in       = '0;
                  state_in   = (pos_ff == '0) ? sste_pkg::S_PUT : sste_pkg::S_INN_RD;
               end else if (j_last) begin
                  state_in = sste_pkg::S_NEXT;
               end else begin
                  j_in     = j_ff + SCW'(1);
                  state_in = sste_pkg::S_INN_RD;
               end
            end else begin
               if (rd_data_ff == x_ff) begin
                  state_in = sste_pkg::S_NEXT;
               end else if (j_ff + SCW'(1) == pos_ff) begin
                  state_in = sste_pkg::S_PUT;
               end else begin
                  j_in     = j_ff + SCW'(1);
                  state_in = sste_pkg::S_INN_RD;
               end
            end
         end
         sste_pkg::S_PUT: begin
            mem_we    = 1'b1;
            mem_wrow  = count_ff[RW-1:0];
            mem_wslot = pos_ff[SW-1:0];
            mem_wdata = x_ff;
            pos_in    = pos_ff + SCW'(1);
            state_in  = sste_pkg::S_NEXT;
         end

         // advance the source slot, or the source set, or finish
         sste_pkg::S_NEXT: begin
            if (i_last || pos_full) begin
               if (op_ff == sste_pkg::OP_UNION && !pass_ff && !pos_full) begin
                  pass_in  = 1'b1;
                  i_in     = '0;
                  state_in = sste_pkg::S_OUT_RD;
               end else begin
                  res_status_in = sste_pkg::ST_OK;
                  res_idx_in    = 3'(count_ff);
                  count_in      = count_ff + CW'(1);
                  state_in      = sste_pkg::S_RESP;
               end
            end else begin
               i_in     = i_ff + SCW'(1);
               state_in = sste_pkg::S_OUT_RD;
            end
         end

         // search and read-out scan
         sste_pkg::S_SCAN_RD: begin
            state_in = sste_pkg::S_SCAN_EX;
         end
         sste_pkg::S_SCAN_EX: begin
            if (op_ff == sste_pkg::OP_SEARCH) begin
               hit_idx_in  = 3'(row_ff);
               hit_elem_in = '0;
               if (rd_data_ff == v_ff || i_last) begin
                  i_in   = '0;
                  row_in = row_ff + CW'(1);
                  end_in = row_next_end;
               end else begin
                  i_in   = i_ff + SCW'(1);
                  end_in = 1'b0;
               end
               if (rd_data_ff == v_ff) begin
                  k_in     = k_ff + sste_pkg::KW'(1);
                  state_in = sste_pkg::S_HIT;
               end else if ((rd_data_ff == v_ff || i_last) && row_next_end) begin
                  state_in = sste_pkg::S_FINAL;
               end else begin
                  state_in = sste_pkg::S_SCAN_RD;
               end
            end else begin
               hit_idx_in  = a_ff;
               hit_elem_in = rd_data_ff;
               i_in        = i_ff + SCW'(1);
               end_in      = i_last;
               if (rd_nz) begin
                  k_in     = k_ff + sste_pkg::KW'(1);
                  state_in = sste_pkg::S_HIT;
               end else if (i_last) begin
                  state_in = sste_pkg::S_FINAL;
               end else begin
                  state_in = sste_pkg::S_SCAN_RD;
               end
            end
         end

         // hand out the held hit and hold the new one
         sste_pkg::S_HIT: begin
            if (!pend_valid_ff || out_free) begin
               out_load      = pend_valid_ff;
               out_status    = sste_pkg::ST_OK;
               out_idx       = pend_idx_ff;
               out_elem      = pend_elem_ff;
               out_last      = 1'b0;
               pend_valid_in = 1'b1;
               pend_idx_in   = hit_idx_ff;
               pend_elem_in  = hit_elem_ff;
               if (end_ff || k_ff == sste_pkg::KW'(sste_pkg::RESULT_CAP)) begin
                  state_in = sste_pkg::S_FINAL;
               end else begin
                  state_in = sste_pkg::S_SCAN_RD;
               end
            end
         end

         // closing word of a search or read-out
         sste_pkg::S_FINAL: begin
            if (out_free) begin
               out_load = 1'b1;
               out_last = 1'b1;
               if (pend_valid_ff) begin
                  out_status = sste_pkg::ST_OK;
                  out_idx    = pend_idx_ff;
                  out_elem   = pend_elem_ff;
               end else begin
                  out_status = sste_pkg::ST_NONE;
                  out_idx    = (op_ff == sste_pkg::OP_READ) ? a_ff : 3'd0;
               end
               pend_valid_in = 1'b0;
               state_in      = sste_pkg::S_IDLE;
            end
         end

         // single response word
         sste_pkg::S_RESP: begin
            if (out_free) begin
               out_load   = 1'b1;
               out_status = res_status_ff;
               out_idx    = res_idx_ff;
               out_last   = 1'b1;
               state_in   = sste_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = sste_pkg::S_IDLE;
         end
      endcase
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(NUM_SETS))
      else $error("set count beyond table size");

   a_pend_scan: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> (op_ff == sste_pkg::OP_SEARCH || op_ff == sste_pkg::OP_READ))
      else $error("held hit outside search or read-out");

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= SCW'(SET_SLOTS))
      else $error("write position beyond row");

   a_hit_cap: assert property (@(posedge clock) disable iff (reset)
      state_ff == sste_pkg::S_HIT |-> k_ff <= sste_pkg::KW'(sste_pkg::RESULT_CAP))
      else $error("hit count beyond result cap");
`endif

endmodule
`default_nettype wire
